[design/fmrt_pkg.sv]
// Shared types, constants and command/status structs for the first-match
// packet rule table. No dependencies; imported by all design files but fmrt_ram.
package fmrt_pkg;

  // Table geometry.
  localparam int unsigned RulesPerDir = 128;
  localparam int unsigned TableDepth  = 2 * RulesPerDir;
  localparam int unsigned SlotW       = (RulesPerDir > 1) ? $clog2(RulesPerDir) : 1;
  localparam int unsigned EntryW      = $clog2(TableDepth);

  // Field widths of the request and response transactions.
  localparam int unsigned OpW       = 3;
  localparam int unsigned IndexW    = 7;
  localparam int unsigned IfaceW    = 8;
  localparam int unsigned AddrW     = 32;
  localparam int unsigned ProtoW    = 8;
  localparam int unsigned PortW     = 16;
  localparam int unsigned ActionW   = 8;
  localparam int unsigned MatchIdxW = 7;

  // IP protocol numbers that a rule can match.
  localparam logic [ProtoW-1:0] ProtoTcp = 8'd6;
  localparam logic [ProtoW-1:0] ProtoUdp = 8'd17;

  typedef enum logic [OpW-1:0] {
    OP_CLASSIFY = 3'd0,
    OP_ADD      = 3'd1,
    OP_DELETE   = 3'd2,
    OP_EDIT     = 3'd3,
    OP_DUP      = 3'd4,
    OP_SHOW     = 3'd5
  } op_e;

  // One request as taken from the input stream.
  typedef struct packed {
    logic [OpW-1:0]     op;
    logic               dir;
    logic [IndexW-1:0]  index;
    logic [IfaceW-1:0]  iface_id;
    logic [AddrW-1:0]   addr;
    logic [AddrW-1:0]   mask;
    logic [ProtoW-1:0]  proto;
    logic [PortW-1:0]   port;
    logic [ActionW-1:0] action;
  } req_t;

  // One stored rule, as held in the rule memory.
  typedef struct packed {
    logic [AddrW-1:0]   addr;
    logic [AddrW-1:0]   mask;
    logic [IfaceW-1:0]  iface_id;
    logic [ProtoW-1:0]  proto;
    logic [PortW-1:0]   port;
    logic [ActionW-1:0] action;
    logic               dup;
  } rule_t;

  // One response.
  typedef struct packed {
    logic                 status;
    logic                 verdict;
    logic                 matched;
    logic [MatchIdxW-1:0] match_index;
  } res_t;

  typedef enum logic [1:0] {
    ASEL_REQ,
    ASEL_SCAN,
    ASEL_OTHER
  } addr_sel_e;

  typedef enum logic [1:0] {
    WSEL_ADD,
    WSEL_EDIT,
    WSEL_COPY
  } wdata_sel_e;

  typedef enum logic [1:0] {
    RES_ERR,
    RES_OK,
    RES_HIT,
    RES_MISS
  } res_kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_EDIT_WR,
    ST_DUP_CHK,
    ST_DUP_SCAN,
    ST_DUP_SRC,
    ST_CL_SCAN,
    ST_CL_LAST,
    ST_RESP
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load_req;
    logic       ram_re;
    logic       ram_we;
    addr_sel_e  addr_sel;
    wdata_sel_e wdata_sel;
    logic       valid_set;
    logic       valid_clr;
    logic       cnt_clr;
    logic       cnt_inc;
    logic       scan_rd;
    logic       res_load;
    res_kind_e  res_kind;
    logic       out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [OpW-1:0] op;
    logic           in_range;
    logic           entry_valid;
    logic           rule_dup;
    logic           other_free;
    logic           cnt_last;
    logic           hit;
    logic           out_free;
  } sts_t;

endpackage

[design/fmrt_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module fmrt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/fmrt_ctrl.sv]
// Controller state machine of the rule table: sequences table updates,
// duplicate search and classification scans. Depends on fmrt_pkg.
module fmrt_ctrl
  import fmrt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd_o.addr_sel = ASEL_REQ;
        cmd_o.res_load = 1'b1;
        cmd_o.res_kind = RES_ERR;
        state_d        = ST_RESP;
        unique case (sts_i.op)
          OP_CLASSIFY: begin
            cmd_o.res_load = 1'b0;
            cmd_o.cnt_clr  = 1'b1;
            state_d        = ST_CL_SCAN;
          end
          OP_ADD: begin
            if (sts_i.in_range && !sts_i.entry_valid) begin
              cmd_o.ram_we    = 1'b1;
              cmd_o.wdata_sel = WSEL_ADD;
              cmd_o.valid_set = 1'b1;
              cmd_o.res_kind  = RES_OK;
            end
          end
          OP_DELETE: begin
            if (sts_i.entry_valid) begin
              cmd_o.valid_clr = 1'b1;
              cmd_o.res_kind  = RES_OK;
            end
          end
          OP_EDIT: begin
            // Read first so that the duplicated mark is kept.
            if (sts_i.entry_valid) begin
              cmd_o.res_load = 1'b0;
              cmd_o.ram_re   = 1'b1;
              state_d        = ST_EDIT_WR;
            end
          end
          OP_DUP: begin
            if (sts_i.entry_valid) begin
              cmd_o.res_load = 1'b0;
              cmd_o.ram_re   = 1'b1;
              state_d        = ST_DUP_CHK;
            end
          end
          default: begin
            // Show and the unused codes fail.
          end
        endcase
      end
      ST_EDIT_WR: begin
        cmd_o.addr_sel  = ASEL_REQ;
        cmd_o.ram_we    = 1'b1;
        cmd_o.wdata_sel = WSEL_EDIT;
        cmd_o.res_load  = 1'b1;
        cmd_o.res_kind  = RES_OK;
        state_d         = ST_RESP;
      end
      ST_DUP_CHK: begin
        if (sts_i.rule_dup) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_kind = RES_ERR;
          state_d        = ST_RESP;
        end else begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = ST_DUP_SCAN;
        end
      end
      ST_DUP_SCAN: begin
        // Walk the other direction for its lowest free slot.
        cmd_o.addr_sel = ASEL_OTHER;
        if (sts_i.other_free) begin
          cmd_o.ram_we    = 1'b1;
          cmd_o.wdata_sel = WSEL_COPY;
          cmd_o.valid_set = 1'b1;
          state_d         = ST_DUP_SRC;
        end else if (sts_i.cnt_last) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_kind = RES_ERR;
          state_d        = ST_RESP;
        end else begin
          cmd_o.cnt_inc = 1'b1;
        end
      end
      ST_DUP_SRC: begin
        // Mark the source rule as duplicated as well.
        cmd_o.addr_sel  = ASEL_REQ;
        cmd_o.ram_we    = 1'b1;
        cmd_o.wdata_sel = WSEL_COPY;
        cmd_o.res_load  = 1'b1;
        cmd_o.res_kind  = RES_OK;
        state_d         = ST_RESP;
      end
      ST_CL_SCAN: begin
        // One slot read per cycle; the compare works on the read data in the cycle after.
        cmd_o.addr_sel = ASEL_SCAN;
        if (sts_i.hit) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_kind = RES_HIT;
          state_d        = ST_RESP;
        end else begin
          cmd_o.ram_re  = 1'b1;
          cmd_o.scan_rd = 1'b1;
          if (sts_i.cnt_last) begin
            state_d = ST_CL_LAST;
          end else begin
            cmd_o.cnt_inc = 1'b1;
          end
        end
      end
      ST_CL_LAST: begin
        cmd_o.res_load = 1'b1;
        cmd_o.res_kind = sts_i.hit ? RES_HIT : RES_MISS;
        state_d        = ST_RESP;
      end
      ST_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

[design/fmrt_dp.sv]
// Datapath of the rule table: request register, valid bits, rule memory,
// scan counter, match logic and the response register.
// Depends on fmrt_pkg and fmrt_ram.
module fmrt_dp
  import fmrt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  req_t req_i,
  input  cmd_t cmd_i,
  output sts_t sts_o,
  input  logic out_ready_i,
  output logic out_valid_o,
  output res_t out_o
);

  req_t                  req_q;
  logic [TableDepth-1:0] valid_q;
  logic [SlotW-1:0]      cnt_q;
  logic                  rd_pend_q;
  logic                  rd_valid_q;
  logic [SlotW-1:0]      rd_slot_q;
  res_t                  res_q, res_d;
  res_t                  out_q;
  logic                  out_valid_q;

  logic [EntryW-1:0] base, other, a_req, a_scan, a_other, a_sel;
  rule_t             rdata, wdata;
  logic              in_range;

  // Rule match of a stored rule against the held packet.
  function automatic logic rule_match(rule_t r, req_t p);
    logic iface_ok, addr_ok, proto_ok, port_ok, action_ok;
    iface_ok  = (r.iface_id == p.iface_id);
    addr_ok   = ((r.addr & r.mask) == (p.addr & r.mask));
    proto_ok  = ((r.proto == ProtoTcp) && (p.proto == ProtoTcp)) ||
                ((r.proto == ProtoUdp) && (p.proto == ProtoUdp));
    port_ok   = (r.port == '0) || (r.port == p.port);
    action_ok = (r.action <= ActionW'(1));
    return iface_ok && addr_ok && proto_ok && port_ok && action_ok;
  endfunction

  // Request register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q <= req_i;
    end
  end

  // Entry addresses of the two directions.
  assign base     = req_q.dir ? EntryW'(RulesPerDir) : '0;
  assign other    = req_q.dir ? '0 : EntryW'(RulesPerDir);
  assign a_req    = base + EntryW'(req_q.index);
  assign a_scan   = base + EntryW'(cnt_q);
  assign a_other  = other + EntryW'(cnt_q);
  assign in_range = (32'(req_q.index) < RulesPerDir);

  always_comb begin
    unique case (cmd_i.addr_sel)
      ASEL_SCAN:  a_sel = a_scan;
      ASEL_OTHER: a_sel = a_other;
      default:    a_sel = a_req;
    endcase
  end

  // Valid bits, one per entry, cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.valid_set) begin
      valid_q[a_sel] <= 1'b1;
    end else if (cmd_i.valid_clr) begin
      valid_q[a_sel] <= 1'b0;
    end
  end

  // Write data for add, edit and the duplicate copies.
  always_comb begin
    wdata = rdata;
    unique case (cmd_i.wdata_sel)
      WSEL_ADD, WSEL_EDIT: begin
        wdata.addr     = req_q.addr;
        wdata.mask     = req_q.mask;
        wdata.iface_id = req_q.iface_id;
        wdata.proto    = req_q.proto;
        wdata.port     = req_q.port;
        wdata.action   = req_q.action;
        wdata.dup      = (cmd_i.wdata_sel == WSEL_EDIT) ? rdata.dup : 1'b0;
      end
      WSEL_COPY: begin
        wdata.dup = 1'b1;
      end
      default: begin
        wdata = rdata;
      end
    endcase
  end

  // Rule memory for both directions.
  fmrt_ram #(
    .Width ($bits(rule_t)),
    .Depth (TableDepth)
  ) u_rule_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ram_we),
    .waddr_i (a_sel),
    .wdata_i (wdata),
    .re_i    (cmd_i.ram_re),
    .raddr_i (a_sel),
    .rdata_o (rdata)
  );

  // Slot counter shared by the classify scan and the free-slot search.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_clr) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_q <= cnt_q + SlotW'(1);
    end
  end

  // Scan stage that lines the valid bit and slot up with the read data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q  <= 1'b0;
      rd_valid_q <= 1'b0;
      rd_slot_q  <= '0;
    end else begin
      rd_pend_q  <= cmd_i.scan_rd;
      rd_valid_q <= valid_q[a_scan];
      rd_slot_q  <= cnt_q;
    end
  end

  // Response selection.
  always_comb begin
    res_d = '0;
    unique case (cmd_i.res_kind)
      RES_ERR: res_d.status = 1'b1;
      RES_HIT: begin
        res_d.verdict     = rdata.action[0];
        res_d.matched     = 1'b1;
        res_d.match_index = MatchIdxW'(rd_slot_q);
      end
      RES_MISS: res_d.verdict = 1'b1;
      default:  res_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_q <= res_d;
    end
  end

  // Output register towards the response stream.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // Status towards the controller.
  assign sts_o.op          = req_q.op;
  assign sts_o.in_range    = in_range;
  assign sts_o.entry_valid = in_range && valid_q[a_req];
  assign sts_o.rule_dup    = rdata.dup;
  assign sts_o.other_free  = !valid_q[a_other];
  assign sts_o.cnt_last    = (cnt_q == SlotW'(RulesPerDir - 1));
  assign sts_o.hit         = rd_pend_q && rd_valid_q && rule_match(rdata, req_q);
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

endmodule

[design/first_match_packet_rule_table.sv]
// Top level of the first-match packet rule table: stream ports, the
// controller and the datapath. Depends on fmrt_pkg, fmrt_ctrl and fmrt_dp.
//
//   Channel   Direction  Handshake                       Moves
//   s_axis    in         s_axis_tvalid_i/s_axis_tready_o  one request
//   m_axis    out        m_axis_tvalid_o/m_axis_tready_i  one response
//
// One request is handled at a time. Add, delete, show and the checks that
// fail at once go from decode straight to the response; edit and a dup of
// a rule that is already duplicated first pass the edit write or dup check.
// Classify steps through the rule memory one slot per cycle, and dup walks
// the valid bits of the other direction one slot per cycle.
// After reset all rules are empty and the block is ready at once.
// A new request is accepted while the previous response still waits on a
// stalled m_axis; a response stalls the block only when the output register
// is still occupied.
module first_match_packet_rule_table
  import fmrt_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // index[6:0], iface_id[14:7], addr[46:15], mask[78:47], proto[86:79],
  // port[102:87], action[110:103], zero pad[111]
  input  logic [111:0] s_axis_tdata_i,
  // op[2:0], direction[3]
  input  logic [3:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // verdict[0], matched[1], match_index[8:2], zero pad[15:9]
  output logic [15:0]  m_axis_tdata_o,
  // status[0]
  output logic         m_axis_tuser_o
);

  req_t req;
  cmd_t cmd;
  sts_t sts;
  res_t res;

  // Unpack the request transaction.
  assign req.op       = s_axis_tuser_i[2:0];
  assign req.dir      = s_axis_tuser_i[3];
  assign req.index    = s_axis_tdata_i[6:0];
  assign req.iface_id = s_axis_tdata_i[14:7];
  assign req.addr     = s_axis_tdata_i[46:15];
  assign req.mask     = s_axis_tdata_i[78:47];
  assign req.proto    = s_axis_tdata_i[86:79];
  assign req.port     = s_axis_tdata_i[102:87];
  assign req.action   = s_axis_tdata_i[110:103];

  fmrt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fmrt_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_o       (res)
  );

  // Pack the response transaction.
  assign m_axis_tdata_o = {7'd0, res.match_index, res.matched, res.verdict};
  assign m_axis_tuser_o = res.status;

  // A response is never loaded over one that is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("response register overwritten while stalled");

  // Only a classify scan can report a rule hit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.hit |-> (sts.op == OP_CLASSIFY))
    else $error("rule hit outside a classify request");

  // The block holds off a second request while one is in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("request accepted during a request in progress");

  // The rule memory is never read and written in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.ram_we |-> !cmd.ram_re)
    else $error("rule memory read and written together");

endmodule

[tb/rule_table_checker.sv]
// Checker for the first-match packet rule table: watches both stream channels,
// predicts each response from its own copy of the rule tables and compares.
// Depends on fmrt_pkg for the request, rule and response types.
module rule_table_checker
  import fmrt_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  input  logic         s_axis_tready_i,
  input  logic [111:0] s_axis_tdata_i,
  input  logic [3:0]   s_axis_tuser_i,
  input  logic         m_axis_tvalid_i,
  input  logic         m_axis_tready_i,
  input  logic [15:0]  m_axis_tdata_i,
  input  logic         m_axis_tuser_i,
  output int unsigned  fail_count_o,
  output int unsigned  pending_o
);

  // Shadow copy of both rule tables, indexed by direction and then slot.
  bit    slot_used [2][RulesPerDir];
  rule_t slot_rule [2][RulesPerDir];

  // Responses predicted but not yet seen on the output channel.
  res_t  awaited_responses [$];

  // A rule takes every match field from the request and keeps the mark given.
  function automatic rule_t rule_from_request(rule_t prior, req_t r);
    rule_t rule;
    rule          = prior;
    rule.addr     = r.addr;
    rule.mask     = r.mask;
    rule.iface_id = r.iface_id;
    rule.proto    = r.proto;
    rule.port     = r.port;
    rule.action   = r.action;
    return rule;
  endfunction

  // Interface, masked address, TCP or UDP on both sides, port or wildcard,
  // and an action that is either drop or accept.
  function automatic bit rule_fires(rule_t rule, req_t pkt);
    bit proto_ok;
    proto_ok = (rule.proto == ProtoTcp && pkt.proto == ProtoTcp) ||
               (rule.proto == ProtoUdp && pkt.proto == ProtoUdp);
    return (rule.iface_id == pkt.iface_id) &&
           ((rule.addr & rule.mask) == (pkt.addr & rule.mask)) &&
           proto_ok &&
           (rule.port == '0 || rule.port == pkt.port) &&
           (rule.action[ActionW-1:1] == '0);
  endfunction

  // Applies one request to the shadow tables and returns its response.
  function automatic res_t predict_response(req_t r);
    res_t        res;
    logic        side;
    logic        far;
    int unsigned slot;
    rule_t       copy;
    res        = '0;
    res.status = 1'b1;
    side       = r.dir;
    far        = ~r.dir;
    slot       = 32'(r.index);
    if (r.op == OP_CLASSIFY) begin
      res.status  = 1'b0;
      res.verdict = 1'b1;
      for (int i = 0; i < RulesPerDir; i++) begin
        if (slot_used[side][i] && rule_fires(slot_rule[side][i], r)) begin
          res.verdict     = slot_rule[side][i].action[0];
          res.matched     = 1'b1;
          res.match_index = i[MatchIdxW-1:0];
          break;
        end
      end
    end else if (slot < RulesPerDir) begin
      case (r.op)
        OP_ADD: begin
          if (!slot_used[side][slot]) begin
            slot_rule[side][slot]     = rule_from_request('0, r);
            slot_used[side][slot]     = 1'b1;
            res.status                = 1'b0;
          end
        end
        OP_DELETE: begin
          if (slot_used[side][slot]) begin
            slot_used[side][slot] = 1'b0;
            res.status            = 1'b0;
          end
        end
        OP_EDIT: begin
          if (slot_used[side][slot]) begin
            slot_rule[side][slot] = rule_from_request(slot_rule[side][slot], r);
            res.status            = 1'b0;
          end
        end
        OP_DUP: begin
          // The copy goes to the lowest free slot of the other table.
          if (slot_used[side][slot] && !slot_rule[side][slot].dup) begin
            for (int i = 0; i < RulesPerDir; i++) begin
              if (!slot_used[far][i]) begin
                copy                       = slot_rule[side][slot];
                copy.dup                   = 1'b1;
                slot_rule[far][i]          = copy;
                slot_used[far][i]          = 1'b1;
                slot_rule[side][slot].dup  = 1'b1;
                res.status                 = 1'b0;
                break;
              end
            end
          end
        end
        default: begin
          // Show and the spare codes always report an error.
        end
      endcase
    end
    return res;
  endfunction

  function automatic void check_field(string name, logic [6:0] wanted, logic [6:0] seen);
    if (seen !== wanted) begin
      $error("%s: expected %0d, actual %0d", name, wanted, seen);
      fail_count_o++;
    end
  endfunction

  // Responses are compared before the request of the same edge is predicted,
  // since a response never leaves in the cycle its request arrives.
  always @(posedge clk_i or negedge rst_ni) begin
    res_t seen;
    res_t wanted;
    req_t request;
    if (!rst_ni) begin
      foreach (slot_used[d, s]) slot_used[d][s] = 1'b0;
      awaited_responses.delete();
      pending_o = 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        seen.status      = m_axis_tuser_i;
        seen.verdict     = m_axis_tdata_i[0];
        seen.matched     = m_axis_tdata_i[1];
        seen.match_index = m_axis_tdata_i[8:2];
        if (awaited_responses.size() == 0) begin
          $error("response transaction with no request outstanding");
          fail_count_o++;
        end else begin
          wanted = awaited_responses.pop_front();
          check_field("status", 7'(wanted.status), 7'(seen.status));
          check_field("verdict", 7'(wanted.verdict), 7'(seen.verdict));
          check_field("matched", 7'(wanted.matched), 7'(seen.matched));
          check_field("match_index", wanted.match_index, seen.match_index);
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        request.op  = s_axis_tuser_i[2:0];
        request.dir = s_axis_tuser_i[3];
        {request.action, request.port, request.proto, request.mask, request.addr,
         request.iface_id, request.index} = s_axis_tdata_i[110:0];
        awaited_responses.push_back(predict_response(request));
      end
      pending_o = awaited_responses.size();
    end
  end

endmodule

[tb/testbench.sv]
// Top of the rule table testbench: clock, reset, request stimulus and the
// response stall pattern. Depends on fmrt_pkg, the block and rule_table_checker.
module testbench;
  import fmrt_pkg::*;

  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned HoldCycles    = 400;
  localparam int unsigned HoldAfter     = 300;
  localparam int unsigned RandomItems   = 1700;

  localparam logic [OpW-1:0]     OpSpareLo    = 3'd6;
  localparam logic [OpW-1:0]     OpSpareHi    = 3'd7;
  localparam logic               DirIn        = 1'b0;
  localparam logic               DirOut       = 1'b1;
  localparam logic [ActionW-1:0] ActionDrop   = 8'd0;
  localparam logic [ActionW-1:0] ActionAccept = 8'd1;
  localparam logic [ProtoW-1:0]  ProtoIcmp    = 8'd1;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_mode_e;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         req_valid  = 1'b0;
  logic [111:0] req_data   = '0;
  logic [3:0]   req_user   = '0;
  logic         resp_ready = 1'b0;
  logic         req_ready;
  logic         resp_valid;
  logic [15:0]  resp_data;
  logic         resp_status;
  int unsigned  fail_count;
  int unsigned  pending;
  int unsigned  requests_sent = 0;
  int unsigned  burst_left    = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  first_match_packet_rule_table u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (req_valid),
    .s_axis_tready_o (req_ready),
    .s_axis_tdata_i  (req_data),
    .s_axis_tuser_i  (req_user),
    .m_axis_tvalid_o (resp_valid),
    .m_axis_tready_i (resp_ready),
    .m_axis_tdata_o  (resp_data),
    .m_axis_tuser_o  (resp_status)
  );

  rule_table_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (req_valid),
    .s_axis_tready_i (req_ready),
    .s_axis_tdata_i  (req_data),
    .s_axis_tuser_i  (req_user),
    .m_axis_tvalid_i (resp_valid),
    .m_axis_tready_i (resp_ready),
    .m_axis_tdata_i  (resp_data),
    .m_axis_tuser_i  (resp_status),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  // Requests go out in bursts; a new burst follows a gap of random length.
  task automatic send_request(req_t r);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      @(negedge clk);
      req_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
    end
    @(negedge clk);
    req_valid <= 1'b1;
    req_user  <= {r.dir, r.op};
    req_data  <= {1'b0, r.action, r.port, r.proto, r.mask, r.addr, r.iface_id, r.index};
    do @(posedge clk); while (!req_ready);
    burst_left--;
    requests_sent++;
  endtask

  task automatic issue(logic [OpW-1:0] op, logic side, logic [IndexW-1:0] slot,
                       logic [IfaceW-1:0] iface, logic [AddrW-1:0] addr,
                       logic [AddrW-1:0] mask, logic [ProtoW-1:0] proto,
                       logic [PortW-1:0] port, logic [ActionW-1:0] action);
    req_t r;
    r.op       = op;
    r.dir      = side;
    r.index    = slot;
    r.iface_id = iface;
    r.addr     = addr;
    r.mask     = mask;
    r.proto    = proto;
    r.port     = port;
    r.action   = action;
    send_request(r);
  endtask

  // Small pools of values so that rules and packets meet often.
  function automatic logic [IfaceW-1:0] pick_iface();
    case ($urandom_range(0, 3))
      0:       return 8'd3;
      1:       return 8'd4;
      2:       return 8'd200;
      default: return IfaceW'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [AddrW-1:0] pick_base();
    case ($urandom_range(0, 2))
      0:       return 32'h0A00_0000;
      1:       return 32'hC0A8_0100;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [ProtoW-1:0] pick_proto();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 4) return ProtoTcp;
    if (roll < 8) return ProtoUdp;
    return ProtoW'($urandom_range(0, 255));
  endfunction

  function automatic logic [PortW-1:0] pick_port();
    case ($urandom_range(0, 5))
      0:       return 16'd0;
      1:       return 16'd22;
      2:       return 16'd80;
      3:       return 16'd443;
      4:       return 16'd53;
      default: return PortW'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [IndexW-1:0] pick_slot();
    if ($urandom_range(0, 3) != 0) return IndexW'($urandom_range(0, 9));
    return IndexW'($urandom_range(0, 127));
  endfunction

  // A rule with a prefix mask; now and then an action outside drop and accept.
  function automatic req_t random_rule(logic [OpW-1:0] op, logic side, logic [IndexW-1:0] slot);
    req_t        r;
    int unsigned prefix;
    prefix     = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32) : $urandom_range(8, 32);
    r.op       = op;
    r.dir      = side;
    r.index    = slot;
    r.iface_id = pick_iface();
    r.mask     = (prefix == 0) ? '0 : ({AddrW{1'b1}} << (AddrW - prefix));
    r.addr     = pick_base() ^ ($urandom & ~r.mask);
    r.proto    = pick_proto();
    r.port     = pick_port();
    if ($urandom_range(0, 9) < 8)
      r.action = $urandom_range(0, 1) ? ActionAccept : ActionDrop;
    else
      r.action = ActionW'($urandom_range(2, 255));
    return r;
  endfunction

  function automatic req_t random_packet(logic side);
    req_t r;
    r.op       = OP_CLASSIFY;
    r.dir      = side;
    r.index    = IndexW'($urandom_range(0, 127));
    r.iface_id = pick_iface();
    r.addr     = pick_base() ^ ($urandom_range(0, 1) ? $urandom_range(0, 255) : $urandom);
    r.mask     = $urandom;
    r.proto    = pick_proto();
    r.port     = pick_port();
    r.action   = ActionW'($urandom_range(0, 255));
    return r;
  endfunction

  function automatic req_t random_noise();
    req_t r;
    r.op       = OpW'($urandom_range(0, 7));
    r.dir      = 1'($urandom_range(0, 1));
    r.index    = IndexW'($urandom_range(0, 127));
    r.iface_id = IfaceW'($urandom_range(0, 255));
    r.addr     = $urandom;
    r.mask     = $urandom;
    r.proto    = ProtoW'($urandom_range(0, 255));
    r.port     = PortW'($urandom_range(0, 65535));
    r.action   = ActionW'($urandom_range(0, 255));
    return r;
  endfunction

  // Fills one table completely, tries a copy into it, classifies against the
  // full table and then empties it again.
  task automatic fill_and_drain(logic side);
    req_t r;
    for (int s = 0; s < RulesPerDir; s++) send_request(random_rule(OP_ADD, side, IndexW'(s)));
    r = random_rule(OP_ADD, ~side, pick_slot());
    send_request(r);
    r.op = OP_DUP;
    send_request(r);
    repeat (10) send_request(random_packet(side));
    for (int s = 0; s < RulesPerDir; s++) begin
      r       = random_noise();
      r.op    = OP_DELETE;
      r.dir   = side;
      r.index = IndexW'(s);
      send_request(r);
    end
  endtask

  // Receiver: stall pattern changes after a span of random length; once, it holds
  // off for a long stretch so that the block backs up into its input.
  initial begin : receiver
    stall_mode_e mode;
    int unsigned span;
    bit          held;
    held = 1'b0;
    @(posedge rst_n);
    forever begin
      mode = stall_mode_e'($urandom_range(0, 3));
      span = $urandom_range(10, 120);
      repeat (span) begin
        @(negedge clk);
        if (!held && requests_sent >= HoldAfter) begin
          held = 1'b1;
          resp_ready <= 1'b0;
          repeat (HoldCycles) @(negedge clk);
        end
        case (mode)
          STALL_NONE:   resp_ready <= 1'b1;
          STALL_RANDOM: resp_ready <= 1'($urandom_range(0, 1));
          STALL_HEAVY:  resp_ready <= ($urandom_range(0, 3) == 0);
          default:      resp_ready <= ~resp_ready;
        endcase
      end
    end
  end

  // Ends the run when no transaction happens on either channel for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk);
      if ((req_valid && req_ready) || (resp_valid && resp_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    int unsigned target;
    int unsigned roll;
    int unsigned start;
    bit          first_fill;
    bit          second_fill;
    req_t        r;
    first_fill  = 1'b0;
    second_fill = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Show, the spare codes, classify and every maintenance op but add on an empty table.
    issue(OP_SHOW, DirIn, 0, 0, 0, 0, 0, 0, 0);
    issue(OpSpareLo, DirOut, 127, 8'hFF, '1, '1, 8'hFF, 16'hFFFF, 8'hFF);
    issue(OpSpareHi, DirIn, 5, 3, 32'h0A00_0001, '1, ProtoTcp, 80, ActionAccept);
    issue(OP_CLASSIFY, DirIn, 0, 3, 32'h0A00_0001, 0, ProtoTcp, 80, 0);
    issue(OP_DELETE, DirIn, 127, 0, 0, 0, 0, 0, 0);
    issue(OP_EDIT, DirIn, 127, 0, 0, 0, 0, 0, 0);
    issue(OP_DUP, DirIn, 127, 0, 0, 0, 0, 0, 0);
    // All-ones rule in the last slot, then an add onto an occupied slot.
    issue(OP_ADD, DirIn, 127, 8'hFF, '1, '1, ProtoTcp, 16'hFFFF, ActionDrop);
    issue(OP_ADD, DirIn, 127, 1, 0, 0, ProtoUdp, 0, ActionAccept);
    issue(OP_CLASSIFY, DirIn, 0, 8'hFF, '1, 0, ProtoTcp, 16'hFFFF, 0);
    // Wildcard rule in the first slot: any address, any port, UDP only.
    issue(OP_ADD, DirIn, 0, 0, 0, 0, ProtoUdp, 0, ActionAccept);
    issue(OP_CLASSIFY, DirIn, 0, 0, 32'h1234_5678, 0, ProtoUdp, 1234, 0);
    issue(OP_CLASSIFY, DirIn, 0, 0, 32'h1234_5678, 0, ProtoTcp, 1234, 0);
    // A rule with an invalid action is skipped until it is edited.
    issue(OP_ADD, DirIn, 1, 7, 32'hC0A8_0100, 32'hFFFF_FF00, ProtoTcp, 80, 8'hFF);
    issue(OP_CLASSIFY, DirIn, 0, 7, 32'hC0A8_01AB, 0, ProtoTcp, 80, 0);
    issue(OP_EDIT, DirIn, 1, 7, 32'hC0A8_0100, 32'hFFFF_FF00, ProtoTcp, 80, ActionAccept);
    issue(OP_CLASSIFY, DirIn, 0, 7, 32'hC0A8_01AB, 0, ProtoTcp, 80, 0);
    // Copy across, then a second copy of an already marked rule.
    issue(OP_DUP, DirIn, 1, 0, 0, 0, 0, 0, 0);
    issue(OP_DUP, DirIn, 1, 0, 0, 0, 0, 0, 0);
    issue(OP_CLASSIFY, DirOut, 0, 7, 32'hC0A8_01AB, 0, ProtoTcp, 80, 0);
    issue(OP_EDIT, DirOut, 0, 7, 32'hC0A8_0100, 32'hFFFF_FF00, ProtoTcp, 0, ActionDrop);
    issue(OP_DUP, DirOut, 0, 0, 0, 0, 0, 0, 0);
    // A protocol other than TCP or UDP never matches.
    issue(OP_ADD, DirOut, 5, 9, 0, 0, ProtoIcmp, 0, ActionDrop);
    issue(OP_CLASSIFY, DirOut, 0, 9, 32'hDEAD_BEEF, 0, ProtoIcmp, 0, 0);
    issue(OP_DELETE, DirIn, 127, 0, 0, 0, 0, 0, 0);
    issue(OP_DELETE, DirIn, 127, 0, 0, 0, 0, 0, 0);

    // Random mix of table maintenance and classification, with two passes
    // that fill a whole table.
    start  = requests_sent;
    target = start + RandomItems;
    while (requests_sent < target) begin
      if (!first_fill && requests_sent >= start + 400) begin
        first_fill = 1'b1;
        fill_and_drain(1'($urandom_range(0, 1)));
      end else if (!second_fill && requests_sent >= start + 1100) begin
        second_fill = 1'b1;
        fill_and_drain(1'($urandom_range(0, 1)));
      end
      roll = $urandom_range(0, 99);
      if (roll < 30) begin
        send_request(random_packet(1'($urandom_range(0, 1))));
      end else if (roll < 55) begin
        send_request(random_rule(OP_ADD, 1'($urandom_range(0, 1)), pick_slot()));
      end else if (roll < 65) begin
        r       = random_noise();
        r.op    = OP_DELETE;
        r.index = pick_slot();
        send_request(r);
      end else if (roll < 75) begin
        send_request(random_rule(OP_EDIT, 1'($urandom_range(0, 1)), pick_slot()));
      end else if (roll < 85) begin
        r       = random_noise();
        r.op    = OP_DUP;
        r.index = pick_slot();
        send_request(r);
      end else if (roll < 88) begin
        r    = random_noise();
        r.op = OP_SHOW;
        send_request(r);
      end else begin
        send_request(random_noise());
      end
    end

    @(negedge clk);
    req_valid <= 1'b0;
    wait (pending == 0);
    repeat (RulesPerDir + 10) @(posedge clk);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

[first_match_packet_rule_table.f]
design/fmrt_pkg.sv
design/fmrt_ram.sv
design/fmrt_ctrl.sv
design/fmrt_dp.sv
design/first_match_packet_rule_table.sv
tb/rule_table_checker.sv
tb/testbench.sv
